// ----- rtl/clif_pkg.sv -----
`timescale 1ns / 1ps

package clif_pkg;

    localparam int unsigned NEURON_COUNT_DEFAULT = 1024;

    localparam int unsigned INDEX_W   = 10;
    localparam int unsigned COUNT_W   = 17;
    localparam int unsigned VOLT_W    = 32;
    localparam int unsigned COND_W    = 24;
    localparam int unsigned SCALE_W   = 24;
    localparam int unsigned REFR_W    = 16;
    localparam int unsigned DG_W      = 40;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 32;

    localparam logic [VOLT_W-1:0]  REST_LEVEL_RESET          = -32'sd257698038;
    localparam logic [VOLT_W-1:0]  INHIBITORY_REVERSAL_RESET = -32'sd343597384;
    localparam logic [VOLT_W-1:0]  FIRE_THRESHOLD_RESET      = -32'sd214748365;
    localparam logic [SCALE_W-1:0] LEAK_STEP_RESET           = 24'd83886;
    localparam logic [SCALE_W-1:0] EXCIT_DECAY_RESET         = 24'd16445006;
    localparam logic [SCALE_W-1:0] INHIB_DECAY_RESET         = 24'd16610280;
    localparam logic [REFR_W-1:0]  REFRACTORY_TICKS_RESET    = 16'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REST_LEVEL,
        REG_INHIBITORY_REVERSAL,
        REG_FIRE_THRESHOLD,
        REG_LEAK_STEP,
        REG_EXCIT_DECAY,
        REG_INHIB_DECAY,
        REG_REFRACTORY_TICKS
    } reg_index_t;

    typedef struct packed {
        logic [VOLT_W-1:0]  rest_level;
        logic [VOLT_W-1:0]  inhibitory_reversal;
        logic [VOLT_W-1:0]  fire_threshold;
        logic [SCALE_W-1:0] leak_step;
        logic [SCALE_W-1:0] excit_decay;
        logic [SCALE_W-1:0] inhib_decay;
        logic [REFR_W-1:0]  refractory_ticks;
    } cfg_t;

    typedef struct packed {
        logic [VOLT_W-1:0] membrane;
        logic [REFR_W-1:0] refractory;
    } store_rd_t;

    typedef struct packed {
        logic              en;
        logic [VOLT_W-1:0] membrane;
        logic [REFR_W-1:0] refractory;
    } store_wr_t;

    // Entries reachable through the index field
    function automatic int unsigned store_depth(input int unsigned count);
        return (count < (1 << INDEX_W)) ? count : (1 << INDEX_W);
    endfunction

    function automatic int unsigned addr_width(input int unsigned count);
        return (store_depth(count) > 1) ? $clog2(store_depth(count)) : 1;
    endfunction

endpackage

// ----- rtl/clif_step_if.sv -----
`timescale 1ns / 1ps

interface clif_step_if import clif_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [INDEX_W-1:0]       neuron_index;
    logic [COND_W-1:0]        excit_conductance;
    logic [COND_W-1:0]        inhib_conductance;
    logic signed [VOLT_W-1:0] drive_current;

    modport source (
        output valid,
        output neuron_index,
        output excit_conductance,
        output inhib_conductance,
        output drive_current,
        input  ready
    );

    modport sink (
        input  valid,
        input  neuron_index,
        input  excit_conductance,
        input  inhib_conductance,
        input  drive_current,
        output ready
    );

endinterface

// ----- rtl/clif_result_if.sv -----
`timescale 1ns / 1ps

interface clif_result_if import clif_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [INDEX_W-1:0]       neuron_out;
    logic                     spike;
    logic signed [VOLT_W-1:0] membrane_out;
    logic [COND_W-1:0]        excit_conductance_next;
    logic [COND_W-1:0]        inhib_conductance_next;

    modport source (
        output valid,
        output neuron_out,
        output spike,
        output membrane_out,
        output excit_conductance_next,
        output inhib_conductance_next,
        input  ready
    );

    modport sink (
        input  valid,
        input  neuron_out,
        input  spike,
        input  membrane_out,
        input  excit_conductance_next,
        input  inhib_conductance_next,
        output ready
    );

endinterface

// ----- rtl/clif_regs.sv -----
`timescale 1ns / 1ps

module clif_regs import clif_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rest_level          <= REST_LEVEL_RESET;
            cfg_reg.inhibitory_reversal <= INHIBITORY_REVERSAL_RESET;
            cfg_reg.fire_threshold      <= FIRE_THRESHOLD_RESET;
            cfg_reg.leak_step           <= LEAK_STEP_RESET;
            cfg_reg.excit_decay         <= EXCIT_DECAY_RESET;
            cfg_reg.inhib_decay         <= INHIB_DECAY_RESET;
            cfg_reg.refractory_ticks    <= REFRACTORY_TICKS_RESET;
        end
        else if (cfg_write_en)
        begin
            case (reg_index_t'(cfg_index))
                REG_REST_LEVEL:          cfg_reg.rest_level          <= cfg_data;
                REG_INHIBITORY_REVERSAL: cfg_reg.inhibitory_reversal <= cfg_data;
                REG_FIRE_THRESHOLD:      cfg_reg.fire_threshold      <= cfg_data;
                REG_LEAK_STEP:           cfg_reg.leak_step        <= cfg_data[SCALE_W-1:0];
                REG_EXCIT_DECAY:         cfg_reg.excit_decay      <= cfg_data[SCALE_W-1:0];
                REG_INHIB_DECAY:         cfg_reg.inhib_decay      <= cfg_data[SCALE_W-1:0];
                REG_REFRACTORY_TICKS:    cfg_reg.refractory_ticks <= cfg_data[REFR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/clif_store.sv -----
`timescale 1ns / 1ps

module clif_store import clif_pkg::*; #(
    parameter int unsigned NEURON_COUNT = NEURON_COUNT_DEFAULT,
    localparam int unsigned AW = addr_width(NEURON_COUNT)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output store_rd_t     rd_data,
    input  logic [AW-1:0] wr_addr,
    input  store_wr_t     wr_req,
    output logic          busy
);

    localparam int unsigned DEPTH = store_depth(NEURON_COUNT);

    logic [VOLT_W-1:0] membrane_mem [DEPTH];
    logic [REFR_W-1:0] refractory_mem [DEPTH];

    logic          clearing_reg;
    logic [AW-1:0] clear_addr_reg;
    store_rd_t     rd_data_reg;

    // Sweep every entry back to rest after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clear_addr_reg == AW'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clear_addr_reg <= clear_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            membrane_mem[clear_addr_reg]   <= REST_LEVEL_RESET;
            refractory_mem[clear_addr_reg] <= '0;
        end
        else if (wr_req.en)
        begin
            membrane_mem[wr_addr]   <= wr_req.membrane;
            refractory_mem[wr_addr] <= wr_req.refractory;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg.membrane   <= membrane_mem[rd_addr];
            rd_data_reg.refractory <= refractory_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

endmodule

// ----- rtl/clif_pipe.sv -----
`timescale 1ns / 1ps

module clif_pipe import clif_pkg::*; #(
    parameter int unsigned NEURON_COUNT = NEURON_COUNT_DEFAULT,
    localparam int unsigned AW = addr_width(NEURON_COUNT)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          store_busy,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  store_rd_t     rd_data,
    output logic [AW-1:0] wr_addr,
    output store_wr_t     wr_req,
    clif_step_if.sink     step,
    clif_result_if.source result
);

    logic          accept;
    logic          step_in_range;
    logic [AW-1:0] step_addr;
    logic          hazard;
    logic          s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, out_ready;

    // Stage 1: store read data arrives
    logic                     s1_valid_reg;
    logic                     s1_range_reg;
    logic [AW-1:0]            s1_addr_reg;
    logic [INDEX_W-1:0]       s1_index_reg;
    logic [COND_W-1:0]        s1_ge_reg;
    logic [COND_W-1:0]        s1_gi_reg;
    logic [VOLT_W-1:0]        s1_drive_reg;

    // Stage 2: products of the synaptic terms
    logic                     s2_valid_reg;
    logic                     s2_range_reg;
    logic [AW-1:0]            s2_addr_reg;
    logic [INDEX_W-1:0]       s2_index_reg;
    logic [VOLT_W-1:0]        s2_m_reg;
    logic [REFR_W-1:0]        s2_refr_reg;
    logic [33:0]              s2_base_reg;
    logic [56:0]              s2_pe_reg;
    logic [57:0]              s2_pi_reg;
    logic [COND_W-1:0]        s2_ge_reg;
    logic [COND_W-1:0]        s2_gi_reg;

    // Stage 3: saturated dg
    logic                     s3_valid_reg;
    logic                     s3_range_reg;
    logic [AW-1:0]            s3_addr_reg;
    logic [INDEX_W-1:0]       s3_index_reg;
    logic [VOLT_W-1:0]        s3_m_reg;
    logic [REFR_W-1:0]        s3_refr_reg;
    logic [DG_W-1:0]          s3_dg_reg;
    logic [COND_W-1:0]        s3_ge_reg;
    logic [COND_W-1:0]        s3_gi_reg;

    // Stage 4: partial products of dg times leak_step
    logic                     s4_valid_reg;
    logic                     s4_range_reg;
    logic [AW-1:0]            s4_addr_reg;
    logic [INDEX_W-1:0]       s4_index_reg;
    logic [VOLT_W-1:0]        s4_m_reg;
    logic [REFR_W-1:0]        s4_refr_reg;
    logic [43:0]              s4_plo_reg;
    logic [44:0]              s4_phi_reg;
    logic [COND_W-1:0]        s4_ge_reg;
    logic [COND_W-1:0]        s4_gi_reg;

    // Stage 5: membrane step
    logic                     s5_valid_reg;
    logic                     s5_range_reg;
    logic [AW-1:0]            s5_addr_reg;
    logic [INDEX_W-1:0]       s5_index_reg;
    logic [VOLT_W-1:0]        s5_m_reg;
    logic [REFR_W-1:0]        s5_refr_reg;
    logic [40:0]              s5_delta_reg;
    logic [COND_W-1:0]        s5_ge_reg;
    logic [COND_W-1:0]        s5_gi_reg;

    // Output register
    logic                     out_valid_reg;
    logic [INDEX_W-1:0]       out_index_reg;
    logic                     out_spike_reg;
    logic [VOLT_W-1:0]        out_membrane_reg;
    logic [COND_W-1:0]        out_ge_reg;
    logic [COND_W-1:0]        out_gi_reg;

    // Stage 1 arithmetic
    logic signed [VOLT_W-1:0] s1_m;
    logic [32:0]              s1_m_rev;
    logic signed [56:0]       pe_next;
    logic signed [57:0]       pi_next;
    logic [33:0]              base_next;
    logic [47:0]              ge_decay_prod;
    logic [47:0]              gi_decay_prod;

    // Stage 2 arithmetic
    logic [59:0]              dg_sum;
    logic [43:0]              dg_full;
    logic [DG_W-1:0]          dg_next;

    // Stage 3 arithmetic
    logic [43:0]              plo_next;
    logic signed [44:0]       phi_next;

    // Stage 4 arithmetic
    logic [64:0]              leak_prod;

    // Stage 5 arithmetic
    logic [41:0]              m_sum;
    logic [VOLT_W-1:0]        m_sat;
    logic                     fire;
    logic                     spike_next;
    logic [VOLT_W-1:0]        membrane_next;
    logic [REFR_W-1:0]        refr_next;

    // Request side
    assign step_addr     = step.neuron_index[AW-1:0];
    assign step_in_range = {{(COUNT_W - INDEX_W){1'b0}}, step.neuron_index}
                           < COUNT_W'(NEURON_COUNT);

    // Hold a request whose entry still has a write pending
    assign hazard = step_in_range && (
                       (s1_valid_reg && s1_range_reg && s1_addr_reg == step_addr)
                    || (s2_valid_reg && s2_range_reg && s2_addr_reg == step_addr)
                    || (s3_valid_reg && s3_range_reg && s3_addr_reg == step_addr)
                    || (s4_valid_reg && s4_range_reg && s4_addr_reg == step_addr)
                    || (s5_valid_reg && s5_range_reg && s5_addr_reg == step_addr));

    assign out_ready = !out_valid_reg || result.ready;
    assign s5_ready  = !s5_valid_reg || out_ready;
    assign s4_ready  = !s4_valid_reg || s5_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;

    assign step.ready = s1_ready && !hazard && !store_busy;
    assign accept     = step.valid && step.ready;

    assign rd_en   = s1_ready;
    assign rd_addr = step_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_ready)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s5_valid_reg;
            end
        end
    end

    // Stage 1 arithmetic
    assign s1_m      = $signed(rd_data.membrane);
    assign s1_m_rev  = {s1_m[VOLT_W-1], s1_m}
                     - {cfg.inhibitory_reversal[VOLT_W-1], cfg.inhibitory_reversal};
    assign pe_next   = $signed({1'b0, s1_ge_reg}) * s1_m;
    assign pi_next   = $signed({1'b0, s1_gi_reg}) * $signed(s1_m_rev);
    assign base_next = {{2{cfg.rest_level[VOLT_W-1]}}, cfg.rest_level}
                     - {{2{s1_m[VOLT_W-1]}}, s1_m}
                     + {{2{s1_drive_reg[VOLT_W-1]}}, s1_drive_reg};
    assign ge_decay_prod = s1_ge_reg * cfg.excit_decay;
    assign gi_decay_prod = s1_gi_reg * cfg.inhib_decay;

    // Stage 2 arithmetic: floor shift by 16, saturate to 40 bits
    assign dg_sum  = {{10{s2_base_reg[33]}}, s2_base_reg, 16'b0}
                   - {{3{s2_pe_reg[56]}}, s2_pe_reg}
                   - {{2{s2_pi_reg[57]}}, s2_pi_reg};
    assign dg_full = dg_sum[59:16];

    always_comb
    begin
        if ((&dg_full[43:DG_W-1]) || !(|dg_full[43:DG_W-1]))
        begin
            dg_next = dg_full[DG_W-1:0];
        end
        else if (dg_full[43])
        begin
            dg_next = {1'b1, {(DG_W - 1){1'b0}}};
        end
        else
        begin
            dg_next = {1'b0, {(DG_W - 1){1'b1}}};
        end
    end

    // Stage 3 arithmetic: split dg in halves of 20 bits
    assign plo_next = s3_dg_reg[19:0] * cfg.leak_step;
    assign phi_next = $signed(s3_dg_reg[DG_W-1:20]) * $signed({1'b0, cfg.leak_step});

    // Stage 4 arithmetic: floor shift by 24
    assign leak_prod = {s4_phi_reg, 20'b0} + {21'b0, s4_plo_reg};

    // Stage 5 arithmetic
    assign m_sum = {{10{s5_m_reg[VOLT_W-1]}}, s5_m_reg} + {s5_delta_reg[40], s5_delta_reg};

    always_comb
    begin
        if ((&m_sum[41:VOLT_W-1]) || !(|m_sum[41:VOLT_W-1]))
        begin
            m_sat = m_sum[VOLT_W-1:0];
        end
        else if (m_sum[41])
        begin
            m_sat = {1'b1, {(VOLT_W - 1){1'b0}}};
        end
        else
        begin
            m_sat = {1'b0, {(VOLT_W - 1){1'b1}}};
        end
    end

    assign fire = $signed(m_sat) > $signed(cfg.fire_threshold);

    always_comb
    begin
        spike_next    = 1'b0;
        membrane_next = cfg.rest_level;
        refr_next     = s5_refr_reg;
        if (s5_range_reg)
        begin
            if (s5_refr_reg != '0)
            begin
                refr_next = s5_refr_reg - 16'd1;
            end
            else if (fire)
            begin
                spike_next = 1'b1;
                refr_next  = cfg.refractory_ticks;
            end
            else
            begin
                membrane_next = m_sat;
            end
        end
    end

    assign wr_addr           = s5_addr_reg;
    assign wr_req.en         = s5_valid_reg && s5_range_reg && out_ready;
    assign wr_req.membrane   = membrane_next;
    assign wr_req.refractory = refr_next;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_range_reg <= step_in_range;
            s1_addr_reg  <= step_addr;
            s1_index_reg <= step.neuron_index;
            s1_ge_reg    <= step.excit_conductance;
            s1_gi_reg    <= step.inhib_conductance;
            s1_drive_reg <= step.drive_current;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_range_reg <= s1_range_reg;
            s2_addr_reg  <= s1_addr_reg;
            s2_index_reg <= s1_index_reg;
            s2_m_reg     <= rd_data.membrane;
            s2_refr_reg  <= rd_data.refractory;
            s2_base_reg  <= base_next;
            s2_pe_reg    <= pe_next;
            s2_pi_reg    <= pi_next;
            s2_ge_reg    <= ge_decay_prod[47:24];
            s2_gi_reg    <= gi_decay_prod[47:24];
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_range_reg <= s2_range_reg;
            s3_addr_reg  <= s2_addr_reg;
            s3_index_reg <= s2_index_reg;
            s3_m_reg     <= s2_m_reg;
            s3_refr_reg  <= s2_refr_reg;
            s3_dg_reg    <= dg_next;
            s3_ge_reg    <= s2_ge_reg;
            s3_gi_reg    <= s2_gi_reg;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_range_reg <= s3_range_reg;
            s4_addr_reg  <= s3_addr_reg;
            s4_index_reg <= s3_index_reg;
            s4_m_reg     <= s3_m_reg;
            s4_refr_reg  <= s3_refr_reg;
            s4_plo_reg   <= plo_next;
            s4_phi_reg   <= phi_next;
            s4_ge_reg    <= s3_ge_reg;
            s4_gi_reg    <= s3_gi_reg;
        end
        if (s5_ready && s4_valid_reg)
        begin
            s5_range_reg <= s4_range_reg;
            s5_addr_reg  <= s4_addr_reg;
            s5_index_reg <= s4_index_reg;
            s5_m_reg     <= s4_m_reg;
            s5_refr_reg  <= s4_refr_reg;
            s5_delta_reg <= leak_prod[64:24];
            s5_ge_reg    <= s4_ge_reg;
            s5_gi_reg    <= s4_gi_reg;
        end
        if (out_ready && s5_valid_reg)
        begin
            out_index_reg    <= s5_index_reg;
            out_spike_reg    <= spike_next;
            out_membrane_reg <= membrane_next;
            out_ge_reg       <= s5_ge_reg;
            out_gi_reg       <= s5_gi_reg;
        end
    end

    assign result.valid                  = out_valid_reg;
    assign result.neuron_out             = out_index_reg;
    assign result.spike                  = out_spike_reg;
    assign result.membrane_out           = out_membrane_reg;
    assign result.excit_conductance_next = out_ge_reg;
    assign result.inhib_conductance_next = out_gi_reg;

endmodule

// ----- rtl/conductance_lif_neuron_update.sv -----
`timescale 1ns / 1ps

// Conductance-based leaky integrate-and-fire update, one neuron step per request.
// neuron_step (valid/ready) carries the neuron index, both conductances and the
// drive term; neuron_result (valid/ready) returns the index, spike flag, new
// membrane and both decayed conductances, one result per request, in order.
// Registers are to be written through cfg_write_en/cfg_index/cfg_data while idle;
// the user must keep to this, as the block does not enforce it. Throughput: one
// request per cycle while no hazard, store sweep or stalled receiver holds it.
// The result is offered once its request has passed the store read, products,
// dg, leak products and the membrane step into the output register. A request
// for a neuron still in flight waits until that neuron's write-back has happened.
// Reset: registers take their reset values, the pipeline empties, and a sweep over
// every stored neuron (NEURON_COUNT, capped at 1024; 1024 by default) loads every
// membrane with the rest level and clears every refractory count; neuron_step.ready
// stays low then. A stalled receiver holds the output register; the stages behind
// it fill and neuron_step.ready drops once the last free stage is taken.
module conductance_lif_neuron_update import clif_pkg::*; #(
    parameter int unsigned NEURON_COUNT = NEURON_COUNT_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    clif_step_if.sink            neuron_step,
    clif_result_if.source        neuron_result
);

    localparam int unsigned AW = addr_width(NEURON_COUNT);

    cfg_t          cfg;
    logic          store_busy;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    store_rd_t     rd_data;
    logic [AW-1:0] wr_addr;
    store_wr_t     wr_req;

    clif_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    clif_store #(
        .NEURON_COUNT (NEURON_COUNT)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_addr (wr_addr),
        .wr_req  (wr_req),
        .busy    (store_busy)
    );

    clif_pipe #(
        .NEURON_COUNT (NEURON_COUNT)
    ) u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .store_busy (store_busy),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_addr    (wr_addr),
        .wr_req     (wr_req),
        .step       (neuron_step),
        .result     (neuron_result)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        store_busy |-> !neuron_step.ready)
    else $error("request taken during the store sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        store_busy |-> !wr_req.en)
    else $error("write-back during the store sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_req.en |=> neuron_result.valid)
    else $error("write-back without a result");

endmodule

// ----- sim/conductance_lif_neuron_update_tb.sv -----
`timescale 1ns / 1ps

module conductance_lif_neuron_update_tb;
    import clif_pkg::*;

    localparam int unsigned NEURON_COUNT  = NEURON_COUNT_DEFAULT;
    localparam int unsigned STEPS_PER_SET = 330;
    localparam int unsigned DIRECTED_ROWS = 13;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam longint DG_MAX = 64'sd549755813887;
    localparam longint DG_MIN = -64'sd549755813888;
    localparam longint VOLT_MAX = 64'sd2147483647;
    localparam longint VOLT_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [INDEX_W-1:0] neuron;
        logic [COND_W-1:0]  excit;
        logic [COND_W-1:0]  inhib;
        logic [VOLT_W-1:0]  drive;
    } step_req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] neuron;
        logic               spike;
        logic [VOLT_W-1:0]  membrane;
        logic [COND_W-1:0]  excit_next;
        logic [COND_W-1:0]  inhib_next;
    } neuron_update_t;

    typedef struct packed {
        step_req_t      rq;
        logic           typed;
        neuron_update_t want;
    } directed_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    clif_step_if   neuron_step ();
    clif_result_if neuron_result ();

    conductance_lif_neuron_update #(
        .NEURON_COUNT(NEURON_COUNT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .neuron_step  (neuron_step),
        .neuron_result(neuron_result)
    );

    cfg_t                     model_cfg;
    logic signed [VOLT_W-1:0] membrane_mem [NEURON_COUNT];
    logic [REFR_W-1:0]        refractory_mem [NEURON_COUNT];
    neuron_update_t           neuron_updates_due[$];
    directed_row_t            directed_rows [DIRECTED_ROWS];
    cfg_t                     settings [4];

    bit          quiet;
    int unsigned requests_sent;
    int unsigned updates_seen;
    int unsigned spikes_seen;
    int unsigned mismatches;
    int unsigned settings_used;
    int unsigned cycle_count;
    int unsigned stall_left;
    bit          stall_done;

    initial begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d updates still due", cycle_count,
                     neuron_updates_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic neuron_update_t integrate_neuron(step_req_t rq);
        neuron_update_t      u;
        longint              rest;
        longint              m;
        longint              sum;
        longint              dg;
        longint              mem_new;
        logic [2*COND_W-1:0] prod;
        rest      = longint'($signed(model_cfg.rest_level));
        mem_new   = rest;
        u.neuron  = rq.neuron;
        u.spike   = 1'b0;
        if (rq.neuron < NEURON_COUNT)
        begin
            m = membrane_mem[rq.neuron];
            if (refractory_mem[rq.neuron] == '0)
            begin
                sum = (rest - m) * 65536
                    - longint'(rq.excit) * m
                    - longint'(rq.inhib) * (m - longint'($signed(model_cfg.inhibitory_reversal)))
                    + longint'($signed(rq.drive)) * 65536;
                dg = sum >>> 16;
                if (dg > DG_MAX)
                    dg = DG_MAX;
                if (dg < DG_MIN)
                    dg = DG_MIN;
                mem_new = m + ((dg * longint'(model_cfg.leak_step)) >>> 24);
                if (mem_new > VOLT_MAX)
                    mem_new = VOLT_MAX;
                if (mem_new < VOLT_MIN)
                    mem_new = VOLT_MIN;
                if (mem_new > longint'($signed(model_cfg.fire_threshold)))
                begin
                    u.spike = 1'b1;
                    mem_new = rest;
                    refractory_mem[rq.neuron] = model_cfg.refractory_ticks;
                end
            end
            else
            begin
                refractory_mem[rq.neuron] = refractory_mem[rq.neuron] - 1'b1;
                mem_new = rest;
            end
            membrane_mem[rq.neuron] = mem_new[VOLT_W-1:0];
        end
        u.membrane   = mem_new[VOLT_W-1:0];
        prod         = rq.excit * model_cfg.excit_decay;
        u.excit_next = prod[2*COND_W-1:COND_W];
        prod         = rq.inhib * model_cfg.inhib_decay;
        u.inhib_next = prod[2*COND_W-1:COND_W];
        return u;
    endfunction

    function automatic step_req_t random_request();
        step_req_t rq;
        rq.neuron = 10'($urandom);
        rq.excit  = 24'($urandom);
        rq.inhib  = 24'($urandom);
        rq.drive  = $urandom;
        if ($urandom_range(99) < 65)
        begin
            // hammer a few neurons so membranes build up and cross threshold
            if ($urandom_range(9) != 0)
                rq.neuron = 10'($urandom_range(15));
            rq.excit = 24'($urandom_range(24'h100000));
            rq.inhib = 24'($urandom_range(24'h040000));
            rq.drive = $signed(rq.drive) >>> $urandom_range(10, 4);
        end
        return rq;
    endfunction

    task automatic report(string field, longint want, longint got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on update %0d, %s: expected %0h, got %0h", updates_seen, field,
                     want, got);
    endtask

    task automatic check_update(neuron_update_t got);
        neuron_update_t want;
        if (neuron_updates_due.size() == 0)
        begin
            report("unexpected update, neuron", 0, got.neuron);
        end
        else
        begin
            want = neuron_updates_due.pop_front();
            if (got.neuron !== want.neuron)
                report("neuron_out", want.neuron, got.neuron);
            if (got.spike !== want.spike)
                report("spike", want.spike, got.spike);
            if (got.membrane !== want.membrane)
                report("membrane_out", want.membrane, got.membrane);
            if (got.excit_next !== want.excit_next)
                report("excit_conductance_next", want.excit_next, got.excit_next);
            if (got.inhib_next !== want.inhib_next)
                report("inhib_conductance_next", want.inhib_next, got.inhib_next);
        end
    endtask

    always @(posedge clk)
    begin
        neuron_update_t got;
        if (rst_n)
        begin
            if (neuron_result.valid && neuron_result.ready)
            begin
                got.neuron     = neuron_result.neuron_out;
                got.spike      = neuron_result.spike;
                got.membrane   = neuron_result.membrane_out;
                got.excit_next = neuron_result.excit_conductance_next;
                got.inhib_next = neuron_result.inhib_conductance_next;
                check_update(got);
                updates_seen++;
                if (got.spike === 1'b1)
                    spikes_seen++;
            end
            // hold off once for a long stretch so the pipeline backs up
            if (!stall_done && updates_seen == 400)
            begin
                stall_left = 300;
                stall_done = 1'b1;
            end
            if (stall_left != 0)
                stall_left--;
            neuron_result.ready <= (stall_left == 0) && (quiet || $urandom_range(99) >= 27);
        end
    end

    task automatic send_request(step_req_t rq, logic typed, neuron_update_t want);
        neuron_update_t calc;
        while (!quiet && $urandom_range(99) < 27)
        begin
            neuron_step.valid <= 1'b0;
            @(posedge clk);
        end
        neuron_step.valid             <= 1'b1;
        neuron_step.neuron_index      <= rq.neuron;
        neuron_step.excit_conductance <= rq.excit;
        neuron_step.inhib_conductance <= rq.inhib;
        neuron_step.drive_current     <= rq.drive;
        do
            @(posedge clk);
        while (!neuron_step.ready);
        calc = integrate_neuron(rq);
        neuron_updates_due.push_back(typed ? want : calc);
        requests_sent++;
    endtask

    task automatic drain();
        neuron_step.valid <= 1'b0;
        while (neuron_updates_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        case (idx)
            REG_REST_LEVEL:          model_cfg.rest_level          = data;
            REG_INHIBITORY_REVERSAL: model_cfg.inhibitory_reversal = data;
            REG_FIRE_THRESHOLD:      model_cfg.fire_threshold      = data;
            REG_LEAK_STEP:           model_cfg.leak_step           = data[SCALE_W-1:0];
            REG_EXCIT_DECAY:         model_cfg.excit_decay         = data[SCALE_W-1:0];
            REG_INHIB_DECAY:         model_cfg.inhib_decay         = data[SCALE_W-1:0];
            REG_REFRACTORY_TICKS:    model_cfg.refractory_ticks    = data[REFR_W-1:0];
            default:                 ;
        endcase
    endtask

    task automatic program_setting(cfg_t c);
        write_reg(REG_REST_LEVEL, c.rest_level);
        write_reg(REG_INHIBITORY_REVERSAL, c.inhibitory_reversal);
        write_reg(REG_FIRE_THRESHOLD, c.fire_threshold);
        write_reg(REG_LEAK_STEP, 32'(c.leak_step));
        write_reg(REG_EXCIT_DECAY, 32'(c.excit_decay));
        write_reg(REG_INHIB_DECAY, 32'(c.inhib_decay));
        write_reg(REG_REFRACTORY_TICKS, 32'(c.refractory_ticks));
        write_reg(REG_UNMAPPED, $urandom);
        cfg_write_en <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        neuron_update_t none;
        cfg_t           rand_cfg;
        none = '0;

        rst_n                         = 1'b0;
        cfg_write_en                  = 1'b0;
        cfg_index                     = '0;
        cfg_data                      = '0;
        neuron_step.valid             = 1'b0;
        neuron_step.neuron_index      = '0;
        neuron_step.excit_conductance = '0;
        neuron_step.inhib_conductance = '0;
        neuron_step.drive_current     = '0;
        neuron_result.ready           = 1'b0;
        quiet                         = 1'b0;
        stall_left                    = 0;
        stall_done                    = 1'b0;
        cycle_count                   = 0;
        requests_sent                 = 0;
        updates_seen                  = 0;
        spikes_seen                   = 0;
        mismatches                    = 0;
        settings_used                 = 1;

        model_cfg = '{REST_LEVEL_RESET, INHIBITORY_REVERSAL_RESET, FIRE_THRESHOLD_RESET,
                      LEAK_STEP_RESET, EXCIT_DECAY_RESET, INHIB_DECAY_RESET,
                      REFRACTORY_TICKS_RESET};
        for (int i = 0; i < NEURON_COUNT; i++)
        begin
            membrane_mem[i]   = REST_LEVEL_RESET;
            refractory_mem[i] = '0;
        end

        directed_rows[0]  = '{'{10'd0, 24'h000000, 24'h000000, 32'h00000000}, 1'b1,
                              '{10'd0, 1'b0, REST_LEVEL_RESET, 24'd0, 24'd0}};
        directed_rows[1]  = '{'{10'd7, 24'hFFFFFF, 24'h000000, 32'h00000000}, 1'b1,
                              '{10'd7, 1'b1, REST_LEVEL_RESET, 24'd16445005, 24'd0}};
        directed_rows[2]  = '{'{10'd7, 24'h000000, 24'hFFFFFF, 32'h80000000}, 1'b1,
                              '{10'd7, 1'b0, REST_LEVEL_RESET, 24'd0, 24'd16610279}};
        directed_rows[3]  = '{'{10'd1023, 24'h000000, 24'h000000, 32'h7FFFFFFF}, 1'b0, none};
        directed_rows[4]  = '{'{10'd1023, 24'h000000, 24'h000000, 32'h80000000}, 1'b0, none};
        directed_rows[5]  = '{'{10'd2, 24'h000000, 24'hFFFFFF, 32'h00000000}, 1'b0, none};
        directed_rows[6]  = '{'{10'd3, 24'hFFFFFF, 24'hFFFFFF, 32'h7FFFFFFF}, 1'b0, none};
        directed_rows[7]  = '{'{10'h2AA, 24'hAAAAAA, 24'h555555, 32'h55555555}, 1'b0, none};
        directed_rows[8]  = '{'{10'h155, 24'h555555, 24'hAAAAAA, 32'hAAAAAAAA}, 1'b0, none};
        directed_rows[9]  = '{'{10'd3, 24'h000000, 24'h000000, 32'h00000000}, 1'b0, none};
        directed_rows[10] = '{'{10'd4, 24'h100000, 24'h000000, 32'h01000000}, 1'b0, none};
        directed_rows[11] = '{'{10'd4, 24'h100000, 24'h000000, 32'h01000000}, 1'b0, none};
        directed_rows[12] = '{'{10'd0, 24'hFFFFFF, 24'h000000, 32'h00000000}, 1'b1,
                              '{10'd0, 1'b1, REST_LEVEL_RESET, 24'd16445005, 24'd0}};

        settings[0] = '{REST_LEVEL_RESET, INHIBITORY_REVERSAL_RESET, FIRE_THRESHOLD_RESET,
                        24'hFFFFFF, EXCIT_DECAY_RESET, INHIB_DECAY_RESET, 16'd3};
        // threshold at the floor and no refractory time: a neuron spikes unless
        // its membrane sits at the floor
        settings[1] = '{32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                        24'h000000, 24'h000000, 24'hFFFFFF, 16'd0};
        // no spikes possible; membranes run into saturation
        settings[2] = '{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        24'hFFFFFF, 24'hFFFFFF, 24'h000000, 16'hFFFF};
        settings[3] = '{REST_LEVEL_RESET, INHIBITORY_REVERSAL_RESET, FIRE_THRESHOLD_RESET,
                        24'h0C0000, EXCIT_DECAY_RESET, INHIB_DECAY_RESET, 16'd7};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
        drain();

        for (int s = 0; s < 5; s++)
        begin
            if (s == 4)
            begin
                rand_cfg.rest_level          = $urandom;
                rand_cfg.inhibitory_reversal = $urandom;
                rand_cfg.fire_threshold      = $urandom;
                rand_cfg.leak_step           = 24'($urandom);
                rand_cfg.excit_decay         = 24'($urandom);
                rand_cfg.inhib_decay         = 24'($urandom);
                rand_cfg.refractory_ticks    = 16'($urandom_range(20));
                program_setting(rand_cfg);
            end
            else
            begin
                program_setting(settings[s]);
            end
            quiet = (s == 2);
            for (int n = 0; n < STEPS_PER_SET; n++)
                send_request(random_request(), 1'b0, none);
            drain();
        end
        quiet = 1'b0;

        repeat (20) @(posedge clk);
        $display("%0d neuron steps checked under %0d register settings, %0d spikes observed",
                 updates_seen, settings_used, spikes_seen);
        $display("%0d field mismatches, %0d updates left unmatched", mismatches,
                 neuron_updates_due.size());
        if (mismatches == 0 && neuron_updates_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
